### hw/rtl/tok_pkg.sv
// Shared widths, configuration codes and unit request types of the kinematics block.
package tok_pkg;

  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 19;
  localparam int unsigned MUL_W      = 33;
  localparam int unsigned PROD_W     = 2 * MUL_W;
  localparam int unsigned DIV_W      = 40;
  localparam int unsigned DVS_W      = 24;
  localparam int unsigned SQ_IN_W    = 40;
  localparam int unsigned SQ_OUT_W   = SQ_IN_W / 2;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_MAX_VELOCITY  = 3'd0,
    REG_MAX_THRUST    = 3'd1,
    REG_SCREEN_WIDTH  = 3'd2,
    REG_SCREEN_HEIGHT = 3'd3,
    REG_WRAP_MARGIN   = 3'd4,
    REG_FRAME_TIME    = 3'd5
  } cfg_reg_e;

  typedef struct packed {
    logic             start;
    logic [DIV_W-1:0] dividend;
    logic [DVS_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [DIV_W-1:0] quot;
  } div_rsp_t;

  typedef struct packed {
    logic               start;
    logic [SQ_IN_W-1:0] radicand;
  } sqrt_req_t;

  typedef struct packed {
    logic                done;
    logic [SQ_OUT_W-1:0] root;
  } sqrt_rsp_t;

endpackage

### hw/rtl/tok_in_if.sv
// Input channel carrying one frame tick per transaction.
interface tok_in_if;
  logic               valid;
  logic               ready;
  logic signed [16:0] rotate_delta;
  logic signed [16:0] thrust_delta;
  logic signed [15:0] local_x;
  logic signed [15:0] local_y;

  modport source (output valid, rotate_delta, thrust_delta, local_x, local_y, input ready);
  modport sink (input valid, rotate_delta, thrust_delta, local_x, local_y, output ready);
endinterface

### hw/rtl/tok_out_if.sv
// Output channel carrying the new object state and transformed point.
interface tok_out_if;
  logic               valid;
  logic               ready;
  logic signed [23:0] pos_x;
  logic signed [23:0] pos_y;
  logic signed [19:0] vel_x;
  logic signed [19:0] vel_y;
  logic [16:0]        heading;
  logic [15:0]        thrust_now;
  logic signed [23:0] world_x;
  logic signed [23:0] world_y;

  modport source (output valid, pos_x, pos_y, vel_x, vel_y, heading, thrust_now, world_x,
                  world_y, input ready);
  modport sink (input valid, pos_x, pos_y, vel_x, vel_y, heading, thrust_now, world_x,
                world_y, output ready);
endinterface

### hw/rtl/tok_cfg_if.sv
// Configuration write channel.
interface tok_cfg_if;
  import tok_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

### hw/rtl/tok_mul.sv
// Shared signed multiplier with a registered product.
module tok_mul (
  input  logic                                 clk_i,
  input  logic signed [tok_pkg::MUL_W-1:0]     a_i,
  input  logic signed [tok_pkg::MUL_W-1:0]     b_i,
  output logic signed [tok_pkg::PROD_W-1:0]    p_o
);
  import tok_pkg::*;

  logic signed [PROD_W-1:0] p_q;

  always_ff @(posedge clk_i) begin
    p_q <= PROD_W'(a_i) * PROD_W'(b_i);
  end

  assign p_o = p_q;
endmodule

### hw/rtl/tok_div.sv
// Restoring unsigned divider, one quotient bit per cycle.
module tok_div (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  tok_pkg::div_req_t  req_i,
  output tok_pkg::div_rsp_t  rsp_o
);
  import tok_pkg::*;

  localparam int unsigned CNT_W = $clog2(DIV_W + 1);

  logic [DIV_W-1:0] quo_q;
  logic [DVS_W-1:0] rem_q;
  logic [DVS_W-1:0] dvs_q;
  logic [CNT_W-1:0] cnt_q;
  logic             busy_q;
  logic             done_q;
  logic [DVS_W:0]   shifted;

  assign shifted = {rem_q, quo_q[DIV_W-1]};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= CNT_W'(DIV_W);
        quo_q  <= req_i.dividend;
        dvs_q  <= req_i.divisor;
        rem_q  <= '0;
      end else if (busy_q) begin
        if (shifted >= {1'b0, dvs_q}) begin
          rem_q <= DVS_W'(shifted - {1'b0, dvs_q});
          quo_q <= {quo_q[DIV_W-2:0], 1'b1};
        end else begin
          rem_q <= shifted[DVS_W-1:0];
          quo_q <= {quo_q[DIV_W-2:0], 1'b0};
        end
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == CNT_W'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  assign rsp_o.done = done_q;
  assign rsp_o.quot = quo_q;
endmodule

### hw/rtl/tok_sqrt.sv
// Digit-by-digit integer square root, one root bit per cycle.
module tok_sqrt (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  tok_pkg::sqrt_req_t req_i,
  output tok_pkg::sqrt_rsp_t rsp_o
);
  import tok_pkg::*;

  localparam int unsigned CNT_W = $clog2(SQ_OUT_W + 1);

  logic [SQ_IN_W-1:0]  rad_q;
  logic [SQ_OUT_W:0]   rem_q;
  logic [SQ_OUT_W-1:0] root_q;
  logic [CNT_W-1:0]    cnt_q;
  logic                busy_q;
  logic                done_q;
  logic [SQ_OUT_W+2:0] shifted;
  logic [SQ_OUT_W+2:0] trial;

  assign shifted = {rem_q, rad_q[SQ_IN_W-1:SQ_IN_W-2]};
  assign trial   = {1'b0, root_q, 2'b01};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= CNT_W'(SQ_OUT_W);
        rad_q  <= req_i.radicand;
        rem_q  <= '0;
        root_q <= '0;
      end else if (busy_q) begin
        if (shifted >= trial) begin
          rem_q  <= (SQ_OUT_W+1)'(shifted - trial);
          root_q <= {root_q[SQ_OUT_W-2:0], 1'b1};
        end else begin
          rem_q  <= (SQ_OUT_W+1)'(shifted);
          root_q <= {root_q[SQ_OUT_W-2:0], 1'b0};
        end
        rad_q <= {rad_q[SQ_IN_W-3:0], 2'b00};
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == CNT_W'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  assign rsp_o.done = done_q;
  assign rsp_o.root = root_q;
endmodule

### hw/rtl/thrust_object_kinematics_step.sv
// Top level: sequencer, state, sine table and configuration of the kinematics block.

// One frame tick is one input transaction and yields one output transaction. The block
// takes a tick when its sequencer is idle and is busy until the result is registered;
// a finished result may wait at the output while the next tick is already taken. The
// sine table index comes from a reciprocal multiplication on the shared multiplier. When
// the speed limit applies, a 20-step square root and two 40-step divides are added. A
// result that is not yet taken holds the sequencer in its last state. All products go
// through one shared registered multiplier. The sine and cosine table is a constant
// memory with a registered read.
module thrust_object_kinematics_step #(
  parameter int SINE_TABLE_ENTRIES = 1024,
  parameter int FRACTION_BITS      = 8
) (
  input  logic clk_i,
  input  logic rst_ni,
  tok_in_if.sink    in_i,
  tok_out_if.source out_o,
  tok_cfg_if.sink   cfg_i
);
  import tok_pkg::*;

  localparam int unsigned IDX_W = $clog2(SINE_TABLE_ENTRIES);
  localparam logic [16:0] TURN = 17'd92160;
  localparam logic [63:0] Q30_ONE = 64'd1073741824;
  localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
  // The full turn is 45 * 2^11, so the index divides by 2^11 and then by 45 in Q25.
  localparam logic [MUL_W-1:0] INV45_Q25 = MUL_W'(745655);

  typedef logic [31:0] rom_t [SINE_TABLE_ENTRIES];

  function automatic logic signed [15:0] sine_q15(input logic [31:0] ph);
    logic [63:0] r;
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] t;
    logic [63:0] s;
    logic [63:0] v;
    r = {34'd0, ph[29:0]};
    if (ph[30]) begin
      r = Q30_ONE - r;
    end
    x  = (r * HALF_PI_Q30) >> 30;
    x2 = (x * x) >> 30;
    t  = Q30_ONE;
    t  = Q30_ONE - ((x2 * t) >> 30) / 110;
    t  = Q30_ONE - ((x2 * t) >> 30) / 72;
    t  = Q30_ONE - ((x2 * t) >> 30) / 42;
    t  = Q30_ONE - ((x2 * t) >> 30) / 20;
    t  = Q30_ONE - ((x2 * t) >> 30) / 6;
    s  = (x * t) >> 30;
    v  = (s + 64'd16384) >> 15;
    if (v > 64'd32767) begin
      v = 64'd32767;
    end
    return ph[31] ? -16'(v) : 16'(v);
  endfunction

  function automatic rom_t build_rom();
    rom_t        rom;
    logic [63:0] ph;
    for (int i = 0; i < SINE_TABLE_ENTRIES; i++) begin
      ph = (64'(i) << 32) / SINE_TABLE_ENTRIES;
      rom[i] = {sine_q15(ph[31:0]), sine_q15(ph[31:0] + 32'h4000_0000)};
    end
    return rom;
  endfunction

  localparam rom_t SINE_ROM = build_rom();

  function automatic logic signed [PROD_W-1:0] rnd(input logic signed [PROD_W-1:0] v,
                                                  input int sh);
    logic [PROD_W-1:0] m;
    m = v[PROD_W-1] ? PROD_W'(-v) : PROD_W'(v);
    m = (m + (PROD_W'(1) << (sh - 1))) >> sh;
    return v[PROD_W-1] ? -$signed(m) : $signed(m);
  endfunction

  function automatic logic signed [23:0] sat24(input logic signed [26:0] v);
    if (v > 27'sd8388607) begin
      return 24'sh7FFFFF;
    end else if (v < -27'sd8388608) begin
      return 24'sh800000;
    end
    return v[23:0];
  endfunction

  function automatic logic signed [19:0] sat20(input logic signed [20:0] v);
    if (v > 21'sd524287) begin
      return 20'sh7FFFF;
    end else if (v < -21'sd524288) begin
      return 20'sh80000;
    end
    return v[19:0];
  endfunction

  typedef enum logic [4:0] {
    S_IDLE, S_IDX_GO, S_IDX_MUL, S_IDX_W, S_ROM, S_TRIG, S_TF, S_AX, S_AY, S_SQX, S_SQY,
    S_CMP, S_RT_GO, S_RT_W, S_RT_SQ, S_RT_FIX, S_DX_GO, S_DX_W, S_DY_MUL, S_DY_GO, S_DY_W,
    S_VEL, S_POS, S_WRAP, S_W1, S_W2, S_W3, S_W4, S_OUT
  } state_e;

  state_e state_q;

  logic [18:0] max_vel_q;
  logic [15:0] max_thr_q;
  logic [11:0] scr_w_q;
  logic [11:0] scr_h_q;
  logic [9:0]  margin_q;
  logic [15:0] ftime_q;

  logic signed [23:0] pos_x_q, pos_y_q;
  logic signed [19:0] vel_x_q, vel_y_q;
  logic [16:0]        ang_q;
  logic [15:0]        thr_q;

  logic signed [15:0] lx_q, ly_q, sn_q, cs_q;
  logic [IDX_W-1:0]   idx_q;
  logic [31:0]        rom_q;
  logic [31:0]        tf_q;
  logic signed [20:0] vx_q, vy_q;
  logic [39:0]        len_q;
  logic [SQ_OUT_W-1:0] root_q;
  logic [DVS_W-1:0]   l_q;
  logic               neg_q;
  logic signed [PROD_W-1:0] acc_q;
  logic signed [23:0] wx_q, wy_q;

  logic               out_valid_q;
  logic signed [23:0] o_pos_x_q, o_pos_y_q, o_wx_q, o_wy_q;
  logic signed [19:0] o_vel_x_q, o_vel_y_q;
  logic [16:0]        o_ang_q;
  logic [15:0]        o_thr_q;

  logic signed [MUL_W-1:0]  mul_a, mul_b;
  logic signed [PROD_W-1:0] p;
  logic [PROD_W-1:0]        p_abs;
  div_req_t                 div_req;
  div_rsp_t                 div_rsp;
  sqrt_req_t                sq_req;
  sqrt_rsp_t                sq_rsp;

  logic signed [18:0] ang_sum;
  logic [16:0]        ang_n;
  logic signed [17:0] thr_sum;
  logic [15:0]        thr_n;
  logic signed [26:0] edge_x, edge_y, low_w;
  logic signed [23:0] edge_xs, edge_ys, low_s;
  logic signed [20:0] q_s;

  tok_mul u_mul (.clk_i(clk_i), .a_i(mul_a), .b_i(mul_b), .p_o(p));
  tok_div u_div (.clk_i(clk_i), .rst_ni(rst_ni), .req_i(div_req), .rsp_o(div_rsp));
  tok_sqrt u_sqrt (.clk_i(clk_i), .rst_ni(rst_ni), .req_i(sq_req), .rsp_o(sq_rsp));

  always_ff @(posedge clk_i) begin
    rom_q <= SINE_ROM[idx_q];
  end

  always_comb begin
    ang_sum = $signed({2'b00, ang_q}) + 19'(in_i.rotate_delta);
    if (ang_sum < 0) begin
      ang_n = 17'(ang_sum + $signed({2'b00, TURN}));
    end else if (ang_sum >= $signed({2'b00, TURN})) begin
      ang_n = 17'(ang_sum - $signed({2'b00, TURN}));
    end else begin
      ang_n = ang_sum[16:0];
    end
    thr_sum = $signed({2'b00, thr_q}) + 18'(in_i.thrust_delta);
    if (thr_sum > $signed({2'b00, max_thr_q})) begin
      thr_n = max_thr_q;
    end else if (thr_sum < 0) begin
      thr_n = '0;
    end else begin
      thr_n = thr_sum[15:0];
    end
  end

  always_comb begin
    edge_x  = $signed(27'({13'd0, scr_w_q} + {14'd0, margin_q}) << FRACTION_BITS);
    edge_y  = $signed(27'({13'd0, scr_h_q} + {14'd0, margin_q}) << FRACTION_BITS);
    low_w   = -$signed(27'({16'd0, margin_q}) << FRACTION_BITS);
    edge_xs = sat24(edge_x);
    edge_ys = sat24(edge_y);
    low_s   = sat24(low_w);
  end

  assign p_abs = p[PROD_W-1] ? PROD_W'(-p) : PROD_W'(p);
  assign q_s   = $signed({1'b0, div_rsp.quot[19:0]});

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state_q)
      S_IDX_GO: begin
        mul_a = $signed(MUL_W'(ang_q));
        mul_b = MUL_W'(SINE_TABLE_ENTRIES);
      end
      S_IDX_MUL: begin
        mul_a = $signed({14'd0, p[29:11]});
        mul_b = $signed(INV45_Q25);
      end
      S_TRIG: begin
        mul_a = $signed(MUL_W'(thr_q));
        mul_b = $signed(MUL_W'(ftime_q));
      end
      S_TF: begin
        mul_a = $signed({1'b0, p[31:0]});
        mul_b = MUL_W'(sn_q);
      end
      S_AX: begin
        mul_a = $signed({1'b0, tf_q});
        mul_b = MUL_W'(cs_q);
      end
      S_AY: begin
        mul_a = MUL_W'(vx_q);
        mul_b = MUL_W'(vx_q);
      end
      S_SQX: begin
        mul_a = MUL_W'(vy_q);
        mul_b = MUL_W'(vy_q);
      end
      S_SQY: begin
        mul_a = $signed(MUL_W'(max_vel_q));
        mul_b = $signed(MUL_W'(max_vel_q));
      end
      S_RT_SQ: begin
        mul_a = $signed(MUL_W'(root_q));
        mul_b = $signed(MUL_W'(root_q));
      end
      S_RT_FIX: begin
        mul_a = MUL_W'(vx_q);
        mul_b = $signed(MUL_W'(max_vel_q));
      end
      S_DY_MUL: begin
        mul_a = MUL_W'(vy_q);
        mul_b = $signed(MUL_W'(max_vel_q));
      end
      S_WRAP: begin
        mul_a = MUL_W'(lx_q);
        mul_b = MUL_W'(cs_q);
      end
      S_W1: begin
        mul_a = MUL_W'(ly_q);
        mul_b = MUL_W'(sn_q);
      end
      S_W2: begin
        mul_a = MUL_W'(lx_q);
        mul_b = MUL_W'(sn_q);
      end
      S_W3: begin
        mul_a = MUL_W'(ly_q);
        mul_b = MUL_W'(cs_q);
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    div_req.start    = (state_q == S_DX_GO) || (state_q == S_DY_GO);
    div_req.dividend = p_abs[DIV_W-1:0];
    div_req.divisor  = l_q;
    sq_req.start     = (state_q == S_RT_GO);
    sq_req.radicand  = len_q;
  end

  assign in_i.ready  = (state_q == S_IDLE);
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_vel_q <= 19'd2560;
      max_thr_q <= 16'd25600;
      scr_w_q   <= 12'd800;
      scr_h_q   <= 12'd600;
      margin_q  <= 10'd20;
      ftime_q   <= 16'd1092;
    end else if (cfg_i.valid) begin
      unique case (cfg_reg_e'(cfg_i.index))
        REG_MAX_VELOCITY:  max_vel_q <= cfg_i.data[18:0];
        REG_MAX_THRUST:    max_thr_q <= cfg_i.data[15:0];
        REG_SCREEN_WIDTH:  scr_w_q   <= cfg_i.data[11:0];
        REG_SCREEN_HEIGHT: scr_h_q   <= cfg_i.data[11:0];
        REG_WRAP_MARGIN:   margin_q  <= cfg_i.data[9:0];
        REG_FRAME_TIME:    ftime_q   <= cfg_i.data[15:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
      pos_x_q     <= '0;
      pos_y_q     <= '0;
      vel_x_q     <= '0;
      vel_y_q     <= '0;
      ang_q       <= '0;
      thr_q       <= '0;
      idx_q       <= '0;
    end else begin
      if (out_valid_q && out_o.ready && (state_q != S_OUT)) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        S_IDLE: begin
          if (in_i.valid) begin
            ang_q   <= ang_n;
            thr_q   <= thr_n;
            lx_q    <= in_i.local_x;
            ly_q    <= in_i.local_y;
            state_q <= S_IDX_GO;
          end
        end
        S_IDX_GO: state_q <= S_IDX_MUL;
        S_IDX_MUL: state_q <= S_IDX_W;
        S_IDX_W: begin
          idx_q   <= p[25 +: IDX_W];
          state_q <= S_ROM;
        end
        S_ROM: state_q <= S_TRIG;
        S_TRIG: begin
          sn_q    <= rom_q[31:16];
          cs_q    <= rom_q[15:0];
          state_q <= S_TF;
        end
        S_TF: begin
          tf_q    <= p[31:0];
          state_q <= S_AX;
        end
        S_AX: begin
          vx_q    <= 21'(vel_x_q) + 21'(rnd(p, 31));
          state_q <= S_AY;
        end
        S_AY: begin
          vy_q    <= 21'(vel_y_q) - 21'(rnd(p, 31));
          state_q <= S_SQX;
        end
        S_SQX: begin
          len_q   <= p[39:0];
          state_q <= S_SQY;
        end
        S_SQY: begin
          len_q   <= len_q + p[39:0];
          state_q <= S_CMP;
        end
        S_CMP: state_q <= (len_q > p[39:0]) ? S_RT_GO : S_VEL;
        S_RT_GO: state_q <= S_RT_W;
        S_RT_W: begin
          if (sq_rsp.done) begin
            root_q  <= sq_rsp.root;
            state_q <= S_RT_SQ;
          end
        end
        S_RT_SQ: state_q <= S_RT_FIX;
        S_RT_FIX: begin
          l_q     <= (p[39:0] < len_q) ? DVS_W'(root_q) + 1'b1 : DVS_W'(root_q);
          state_q <= S_DX_GO;
        end
        S_DX_GO: begin
          neg_q   <= p[PROD_W-1];
          state_q <= S_DX_W;
        end
        S_DX_W: begin
          if (div_rsp.done) begin
            vx_q    <= neg_q ? -q_s : q_s;
            state_q <= S_DY_MUL;
          end
        end
        S_DY_MUL: state_q <= S_DY_GO;
        S_DY_GO: begin
          neg_q   <= p[PROD_W-1];
          state_q <= S_DY_W;
        end
        S_DY_W: begin
          if (div_rsp.done) begin
            vy_q    <= neg_q ? -q_s : q_s;
            state_q <= S_VEL;
          end
        end
        S_VEL: begin
          vel_x_q <= sat20(vx_q);
          vel_y_q <= sat20(vy_q);
          state_q <= S_POS;
        end
        S_POS: begin
          pos_x_q <= sat24(27'(pos_x_q) + 27'(vel_x_q));
          pos_y_q <= sat24(27'(pos_y_q) + 27'(vel_y_q));
          state_q <= S_WRAP;
        end
        S_WRAP: begin
          if (pos_x_q > edge_xs) begin
            pos_x_q <= low_s;
          end else if (pos_x_q < low_s) begin
            pos_x_q <= edge_xs;
          end
          if (pos_y_q > edge_ys) begin
            pos_y_q <= low_s;
          end else if (pos_y_q < low_s) begin
            pos_y_q <= edge_ys;
          end
          state_q <= S_W1;
        end
        S_W1: begin
          acc_q   <= p;
          state_q <= S_W2;
        end
        S_W2: begin
          wx_q    <= sat24(27'(rnd(acc_q - p, 15)) + 27'(pos_x_q));
          state_q <= S_W3;
        end
        S_W3: begin
          acc_q   <= p;
          state_q <= S_W4;
        end
        S_W4: begin
          wy_q    <= sat24(27'(rnd(acc_q + p, 15)) + 27'(pos_y_q));
          state_q <= S_OUT;
        end
        S_OUT: begin
          if (!out_valid_q || out_o.ready) begin
            out_valid_q <= 1'b1;
            o_pos_x_q   <= pos_x_q;
            o_pos_y_q   <= pos_y_q;
            o_vel_x_q   <= vel_x_q;
            o_vel_y_q   <= vel_y_q;
            o_ang_q     <= ang_q;
            o_thr_q     <= thr_q;
            o_wx_q      <= wx_q;
            o_wy_q      <= wy_q;
            state_q     <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign out_o.valid      = out_valid_q;
  assign out_o.pos_x      = o_pos_x_q;
  assign out_o.pos_y      = o_pos_y_q;
  assign out_o.vel_x      = o_vel_x_q;
  assign out_o.vel_y      = o_vel_y_q;
  assign out_o.heading    = o_ang_q;
  assign out_o.thrust_now = o_thr_q;
  assign out_o.world_x    = o_wx_q;
  assign out_o.world_y    = o_wy_q;

  a_heading_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ang_q < TURN) else $error("heading left its range");

  a_div_done_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_rsp.done |-> (state_q == S_DX_W || state_q == S_DY_W))
    else $error("divider finished outside a wait state");

  a_sqrt_done_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sq_rsp.done |-> state_q == S_RT_W) else $error("root finished outside its wait state");

endmodule
